FILE: src/stc_pkg.sv
// Shared types, constants and constant helpers for the seconds-to-date converter.
`timescale 1ns / 1ps
`default_nettype none

package stc_pkg;

   localparam int unsigned SECS_PER_YEAR  = 31536000;
   localparam int unsigned SECS_PER_DAY   = 86400;
   localparam int unsigned SECS_PER_HOUR  = 3600;
   localparam int unsigned SECS_PER_MIN   = 60;
   localparam int unsigned DAYS_LEAP_YEAR = 366;
   localparam int unsigned FEB_END_DAY    = 59;
   localparam int unsigned YEAR_MAX       = 68;
   localparam int unsigned MONTH_LAST     = 11;
   localparam int unsigned DAY_OFFSET_MAX = 30;
   localparam int unsigned HOUR_MAX       = 23;
   localparam int unsigned MINUTE_MAX     = 59;

   // day-of-year at which each month starts, leap-year calendar
   localparam int unsigned MONTH_START [0:11] =
      '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335};

   // fallback record for an out-of-range day of year
   localparam logic [6:0] BAD_YEAR  = 7'd1;
   localparam logic [3:0] BAD_MONTH = 4'd1;
   localparam logic [4:0] BAD_DAY   = 5'd1;

   typedef struct packed {
      logic        negative;
      logic [6:0]  year;
      logic [24:0] rem;
   } year_word_type;

   typedef struct packed {
      logic        negative;
      logic [6:0]  year;
      logic [3:0]  month;
      logic [21:0] rim;
      logic        bad_day;
   } month_word_type;

   typedef struct packed {
      logic        negative;
      logic [6:0]  year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [16:0] sod;
      logic        bad_day;
   } day_word_type;

   typedef struct packed {
      logic        negative;
      logic [6:0]  year_index;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        bad_day;
   } result_word_type;

   // plain 365-day span of k years
   function automatic logic [31:0] year_span(input int k);
      longint unsigned v;
      v = longint'(k) * SECS_PER_YEAR;
      return 32'(v);
   endfunction

   // first second of year k, with one leap day per earlier index 3 mod 4
   function automatic logic [31:0] year_start(input int k);
      longint unsigned v;
      v = longint'(k) * SECS_PER_YEAR + longint'(k >> 2) * SECS_PER_DAY;
      return 32'(v);
   endfunction

endpackage

`default_nettype wire

FILE: src/stc_year.sv
// Year stage: magnitude, year index and seconds into the year.
`timescale 1ns / 1ps
`default_nettype none

module stc_year
   import stc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [31:0] in_seconds,
   output logic             out_valid,
   input  wire logic        out_ready,
   output year_word_type    out_word
);

   logic          valid_ff;
   year_word_type word_ff;
   year_word_type word_in;

   logic          neg;
   logic [31:0]   mag;
   logic [6:0]    year;
   logic [31:0]   base_main;
   logic [31:0]   base_back;
   logic [32:0]   diff;
   logic [31:0]   rem_full;

   always_comb begin
      neg       = in_seconds[31];
      mag       = neg ? (32'd0 - in_seconds) : in_seconds;
      year      = '0;
      base_main = '0;
      base_back = '0;
      for (int k = 1; k <= int'(YEAR_MAX); k++) begin
         if (mag >= year_span(k)) begin
            year      = 7'(k);
            base_main = year_start(k);
            base_back = year_start(k - 1);
         end
      end
      diff = {1'b0, mag} - {1'b0, base_main};
      // leap days pushed us past the boundary: fall back one year
      if (diff[32]) begin
         rem_full = mag - base_back;
         year     = year - 7'd1;
      end else begin
         rem_full = diff[31:0];
      end
      word_in.negative = neg;
      word_in.year     = year;
      word_in.rem      = rem_full[24:0];
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= word_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/stc_month.sv
// Month stage: leap adjustment, month select and seconds into the month.
`timescale 1ns / 1ps
`default_nettype none

module stc_month
   import stc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire year_word_type in_word,
   output logic               out_valid,
   input  wire logic          out_ready,
   output month_word_type     out_word
);

   logic           valid_ff;
   month_word_type word_ff;
   month_word_type word_in;

   logic           leap;
   logic [24:0]    adj;
   logic [3:0]     idx;
   logic [24:0]    base;

   always_comb begin
      leap = (in_word.year[1:0] == 2'b11);
      // non-leap years skip 29 February on the leap calendar
      if (!leap && (in_word.rem >= 25'(FEB_END_DAY * SECS_PER_DAY))) begin
         adj = in_word.rem + 25'(SECS_PER_DAY);
      end else begin
         adj = in_word.rem;
      end
      idx  = '0;
      base = '0;
      for (int m = 1; m <= int'(MONTH_LAST); m++) begin
         if (adj >= 25'(MONTH_START[m] * SECS_PER_DAY)) begin
            idx  = 4'(m);
            base = 25'(MONTH_START[m] * SECS_PER_DAY);
         end
      end
      word_in.negative = in_word.negative;
      word_in.year     = in_word.year;
      word_in.month    = idx + 4'd1;
      word_in.rim      = 22'(adj - base);
      word_in.bad_day  = (adj >= 25'(DAYS_LEAP_YEAR * SECS_PER_DAY));
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= word_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/stc_day.sv
// Day stage: day of month and seconds into the day.
`timescale 1ns / 1ps
`default_nettype none

module stc_day
   import stc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire month_word_type in_word,
   output logic                out_valid,
   input  wire logic           out_ready,
   output day_word_type        out_word
);

   logic         valid_ff;
   day_word_type word_ff;
   day_word_type word_in;

   logic [4:0]   offset;
   logic [21:0]  base;

   always_comb begin
      offset = '0;
      base   = '0;
      for (int k = 1; k <= int'(DAY_OFFSET_MAX); k++) begin
         if (in_word.rim >= 22'(k * SECS_PER_DAY)) begin
            offset = 5'(k);
            base   = 22'(k * SECS_PER_DAY);
         end
      end
      word_in.negative = in_word.negative;
      word_in.year     = in_word.year;
      word_in.month    = in_word.month;
      word_in.day      = offset + 5'd1;
      word_in.sod      = 17'(in_word.rim - base);
      word_in.bad_day  = in_word.bad_day;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= word_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/stc_time.sv
// Time stage: hour, minute, second and the result register.
`timescale 1ns / 1ps
`default_nettype none

module stc_time
   import stc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire day_word_type in_word,
   output logic              out_valid,
   input  wire logic         out_ready,
   output result_word_type   out_word
);

   logic            valid_ff;
   result_word_type word_ff;
   result_word_type word_in;

   logic [4:0]      hour;
   logic [16:0]     hour_base;
   logic [11:0]     rest;
   logic [5:0]      minute;
   logic [11:0]     min_base;
   logic [11:0]     sec_full;

   always_comb begin
      hour      = '0;
      hour_base = '0;
      for (int k = 1; k <= int'(HOUR_MAX); k++) begin
         if (in_word.sod >= 17'(k * SECS_PER_HOUR)) begin
            hour      = 5'(k);
            hour_base = 17'(k * SECS_PER_HOUR);
         end
      end
      rest     = 12'(in_word.sod - hour_base);
      minute   = '0;
      min_base = '0;
      for (int k = 1; k <= int'(MINUTE_MAX); k++) begin
         if (rest >= 12'(k * SECS_PER_MIN)) begin
            minute   = 6'(k);
            min_base = 12'(k * SECS_PER_MIN);
         end
      end
      sec_full = rest - min_base;
      if (in_word.bad_day) begin
         word_in.negative   = 1'b0;
         word_in.year_index = BAD_YEAR;
         word_in.month      = BAD_MONTH;
         word_in.day        = BAD_DAY;
         word_in.hour       = '0;
         word_in.minute     = '0;
         word_in.second     = '0;
         word_in.bad_day    = 1'b1;
      end else begin
         word_in.negative   = in_word.negative;
         word_in.year_index = in_word.year;
         word_in.month      = in_word.month;
         word_in.day        = in_word.day;
         word_in.hour       = hour;
         word_in.minute     = minute;
         word_in.second     = sec_full[5:0];
         word_in.bad_day    = 1'b0;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= word_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/seconds_to_calendar_date.sv
// Converts a signed seconds count into sign, year index, month, day and time of day.
// Takes one word per cycle while req_ready is high and returns one result word
// per input word. The word is registered on entry and then passes four
// compare-and-subtract stages (year, month, day, time of day) on its way to the
// rsp_ outputs. Each stage holds its word while the next stage is
// full, so req_ready drops only when every stage is occupied and rsp_ready is low.
// Years are 365 days with a leap day on every index 3 mod 4; the magnitude of a
// negative count is converted and rsp_negative set. An out-of-range day of year
// (not reachable) returns the default date with rsp_bad_day set.
`timescale 1ns / 1ps
`default_nettype none

module seconds_to_calendar_date
   import stc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_seconds,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_negative,
   output logic [6:0]       rsp_year_index,
   output logic [3:0]       rsp_month,
   output logic [4:0]       rsp_day,
   output logic [4:0]       rsp_hour,
   output logic [5:0]       rsp_minute,
   output logic [5:0]       rsp_second,
   output logic             rsp_bad_day
);

   logic            in_valid_ff;
   logic [31:0]     in_seconds_ff;
   logic            year_ready;
   logic            year_valid;
   year_word_type   year_word;
   logic            month_ready;
   logic            month_valid;
   month_word_type  month_word;
   logic            day_ready;
   logic            day_valid;
   day_word_type    day_word;
   logic            time_ready;
   result_word_type result_word;

   assign req_ready = !in_valid_ff || year_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_seconds_ff <= req_seconds;
      end
   end

   stc_year u_year (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (in_valid_ff),
      .in_ready   (year_ready),
      .in_seconds (in_seconds_ff),
      .out_valid  (year_valid),
      .out_ready  (month_ready),
      .out_word   (year_word)
   );

   stc_month u_month (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (year_valid),
      .in_ready  (month_ready),
      .in_word   (year_word),
      .out_valid (month_valid),
      .out_ready (day_ready),
      .out_word  (month_word)
   );

   stc_day u_day (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (month_valid),
      .in_ready  (day_ready),
      .in_word   (month_word),
      .out_valid (day_valid),
      .out_ready (time_ready),
      .out_word  (day_word)
   );

   stc_time u_time (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (day_valid),
      .in_ready  (time_ready),
      .in_word   (day_word),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (result_word)
   );

   assign rsp_negative   = result_word.negative;
   assign rsp_year_index = result_word.year_index;
   assign rsp_month      = result_word.month;
   assign rsp_day        = result_word.day;
   assign rsp_hour       = result_word.hour;
   assign rsp_minute     = result_word.minute;
   assign rsp_second     = result_word.second;
   assign rsp_bad_day    = result_word.bad_day;

endmodule

`default_nettype wire

FILE: src/stc_checker.sv
// Port-level checks for the seconds-to-date converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module stc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [31:0] req_seconds,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_negative,
   input wire logic [6:0]  rsp_year_index,
   input wire logic [3:0]  rsp_month,
   input wire logic [4:0]  rsp_day,
   input wire logic [4:0]  rsp_hour,
   input wire logic [5:0]  rsp_minute,
   input wire logic [5:0]  rsp_second,
   input wire logic        rsp_bad_day
);

   // a waiting request word holds
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_seconds))
      else $error("request word changed while waiting");

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_negative)
         && $stable(rsp_year_index) && $stable(rsp_month) && $stable(rsp_day)
         && $stable(rsp_hour) && $stable(rsp_minute) && $stable(rsp_second)
         && $stable(rsp_bad_day))
      else $error("result word changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day >= 5'd1
         && rsp_hour <= 5'd23 && rsp_minute <= 6'd59 && rsp_second <= 6'd59
         && rsp_year_index <= 7'd68)
      else $error("result field out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_day |-> !rsp_negative && rsp_year_index == 7'd1
         && rsp_month == 4'd1 && rsp_day == 5'd1 && rsp_hour == 5'd0
         && rsp_minute == 6'd0 && rsp_second == 6'd0)
      else $error("bad day without default date");

   // a draining output always frees the input side
   assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output drains");

endmodule

bind seconds_to_calendar_date stc_checker u_stc_checker (.*);

`default_nettype wire
